[design/scfla_pkg.sv]
package scfla_pkg;

    localparam int ALIGN_SHIFT  = 3;
    localparam int ALIGN_BYTES  = 1 << ALIGN_SHIFT;
    localparam int CLASS_COUNT  = 8;
    localparam int CHUNK_BLOCKS = 64;
    localparam int CHUNK_LIMIT  = 4;
    localparam int CLASS_BLOCKS = CHUNK_LIMIT * CHUNK_BLOCKS;

    localparam int SIZE_W   = 16;
    localparam int SUM_W    = SIZE_W + 1;
    localparam int CFG_W    = 11;
    localparam int CLASS_W  = 3;
    localparam int BLK_W    = 8;
    localparam int STATUS_W = 3;
    localparam int LINK_W   = BLK_W + 1;
    localparam int LADDR_W  = CLASS_W + BLK_W;
    localparam int LINK_DEPTH  = CLASS_COUNT * CLASS_BLOCKS;
    localparam int CHUNK_IDX_W = (CHUNK_BLOCKS > 1) ? $clog2(CHUNK_BLOCKS) : 1;
    localparam int CHUNK_CNT_W = $clog2(CHUNK_LIMIT + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);
    localparam logic [BLK_W:0]   BLK_LIM   = (BLK_W + 1)'(CLASS_BLOCKS);

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_FREED     = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_OVERSIZE  = 3'd3,
        ST_EXHAUSTED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_IGNORE,
        K_OVERSIZE,
        K_ALLOC,
        K_FREE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHAIN,
        S_GRANT
    } t_state;

    typedef struct packed {
        logic             is_null;
        logic [BLK_W-1:0] idx;
    } t_link;

    typedef struct packed {
        logic load_req;
        logic chain_wr;
        logic chain_done;
        logic pop_rd;
        logic fire;
        logic grant;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  head_null;
        logic  chunks_full;
        logic  chain_last;
        logic  out_free;
    } t_sts;

endpackage

[design/scfla_ram.sv]
module scfla_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/scfla_ctrl.sv]
module scfla_ctrl
    import scfla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.kind == K_ALLOC && i_sts.head_null && !i_sts.chunks_full) begin
                    n_state = S_CHAIN;
                end else if (i_sts.kind == K_ALLOC && !i_sts.head_null) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_GRANT;
                end else if (i_sts.out_free) begin
                    o_cmd.fire = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CHAIN: begin
                o_cmd.chain_wr = 1'b1;
                if (i_sts.chain_last) begin
                    o_cmd.chain_done = 1'b1;
                    n_state          = S_EXEC;
                end
            end
            S_GRANT: begin
                if (i_sts.out_free) begin
                    o_cmd.fire  = 1'b1;
                    o_cmd.grant = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_chain_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.chain_wr |-> i_sts.kind == K_ALLOC)
        else $error("chunk chaining outside an allocate");

    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |=> o_in_stall)
        else $error("request taken while busy");

    a_pop_then_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_rd |=> r_state == S_GRANT)
        else $error("pop read not followed by grant");
`endif

endmodule

[design/scfla_dp.sv]
module scfla_dp
    import scfla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_mode,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic                i_handle_present,
    input  logic [BLK_W-1:0]    i_block_handle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [CLASS_W-1:0]  o_size_class,
    output logic [BLK_W-1:0]    o_granted_handle
);

    logic [CFG_W-1:0]       r_lpb;
    t_link                  r_head [CLASS_COUNT];
    logic [CHUNK_CNT_W-1:0] r_chunks [CLASS_COUNT];
    logic [CHUNK_IDX_W-1:0] r_cnt;
    logic                   r_out_valid;

    t_kind                  r_kind;
    logic [CLASS_W-1:0]     r_cls;
    logic [BLK_W-1:0]       r_handle;
    t_status                r_out_status;
    logic [CLASS_W-1:0]     r_out_cls;
    logic [BLK_W-1:0]       r_out_handle;

    logic [SUM_W-1:0]   units;
    logic [SUM_W-1:0]   rounded;
    logic               size_ok;
    logic [CLASS_W-1:0] dec_cls;
    t_kind              dec_kind;

    t_link              head_cur;
    logic [BLK_W-1:0]   chunk_base;
    logic [BLK_W-1:0]   chain_idx;
    logic               chain_last;
    t_link              chain_link;

    logic               mem_we;
    logic [LADDR_W-1:0] mem_waddr;
    t_link              mem_wdata;
    logic [LADDR_W-1:0] mem_raddr;
    logic [LINK_W-1:0]  mem_rdata;

    t_status            res_status;
    logic [CLASS_W-1:0] res_cls;
    logic [BLK_W-1:0]   res_handle;

    // size class decode
    always_comb begin
        units   = (SUM_W'(i_size_bytes) + SUM_W'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT;
        rounded = units << ALIGN_SHIFT;
        size_ok = (units <= (SUM_W'(1) << (CLASS_COUNT - 1))) &&
                  (rounded <= SUM_W'(r_lpb));
        dec_cls = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (units <= (SUM_W'(1) << c)) begin
                dec_cls = CLASS_W'(c);
            end
        end
        if (i_size_bytes == '0 || (i_mode && !i_handle_present)) begin
            dec_kind = K_IGNORE;
        end else if (!size_ok) begin
            dec_kind = K_OVERSIZE;
        end else if (!i_mode) begin
            dec_kind = K_ALLOC;
        end else if ({1'b0, i_block_handle} >= BLK_LIM) begin
            dec_kind = K_IGNORE;
        end else begin
            dec_kind = K_FREE;
        end
    end

    assign head_cur   = r_head[r_cls];
    assign chunk_base = BLK_W'(int'(r_chunks[r_cls]) * CHUNK_BLOCKS);
    assign chain_idx  = chunk_base + BLK_W'(r_cnt);
    assign chain_last = (r_cnt == CHUNK_IDX_W'(CHUNK_BLOCKS - 1));

    always_comb begin
        if (chain_last) begin
            chain_link = '{is_null: 1'b1, idx: '0};
        end else begin
            chain_link = '{is_null: 1'b0, idx: chain_idx + BLK_W'(1)};
        end
    end

    // link store write and read ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_cls, r_handle};
        mem_wdata = head_cur;
        if (i_cmd.chain_wr) begin
            mem_we    = 1'b1;
            mem_waddr = {r_cls, chain_idx};
            mem_wdata = chain_link;
        end else if (i_cmd.fire && !i_cmd.grant && r_kind == K_FREE) begin
            mem_we = 1'b1;
        end
    end

    assign mem_raddr = {r_cls, head_cur.idx};

    scfla_ram #(
        .WIDTH(LINK_W),
        .DEPTH(LINK_DEPTH)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (i_cmd.pop_rd),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // result selection
    always_comb begin
        res_status = ST_IGNORED;
        res_cls    = '0;
        res_handle = '0;
        if (i_cmd.grant) begin
            res_status = ST_GRANTED;
            res_cls    = r_cls;
            res_handle = head_cur.idx;
        end else begin
            case (r_kind)
                K_IGNORE: begin
                    res_status = ST_IGNORED;
                end
                K_OVERSIZE: begin
                    res_status = ST_OVERSIZE;
                end
                K_FREE: begin
                    res_status = ST_FREED;
                    res_cls    = r_cls;
                end
                K_ALLOC: begin
                    res_status = ST_EXHAUSTED;
                    res_cls    = r_cls;
                end
                default: begin
                    res_status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpb       <= CFG_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_head[c]   <= '{is_null: 1'b1, idx: '0};
                r_chunks[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_lpb <= i_cfg_wdata;
            end
            if (i_cmd.chain_wr) begin
                r_cnt <= chain_last ? '0 : r_cnt + CHUNK_IDX_W'(1);
            end
            if (i_cmd.chain_done) begin
                r_head[r_cls]   <= '{is_null: 1'b0, idx: chunk_base};
                r_chunks[r_cls] <= r_chunks[r_cls] + CHUNK_CNT_W'(1);
            end
            if (i_cmd.fire && i_cmd.grant) begin
                r_head[r_cls] <= t_link'(mem_rdata);
            end else if (i_cmd.fire && r_kind == K_FREE) begin
                r_head[r_cls] <= '{is_null: 1'b0, idx: r_handle};
            end
            if (i_cmd.fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind   <= dec_kind;
            r_cls    <= dec_cls;
            r_handle <= i_block_handle;
        end
        if (i_cmd.fire) begin
            r_out_status <= res_status;
            r_out_cls    <= res_cls;
            r_out_handle <= res_handle;
        end
    end

    assign o_sts.kind        = r_kind;
    assign o_sts.head_null   = head_cur.is_null;
    assign o_sts.chunks_full = (r_chunks[r_cls] >= CHUNK_CNT_W'(CHUNK_LIMIT));
    assign o_sts.chain_last  = chain_last;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_size_class     = r_out_cls;
    assign o_granted_handle = r_out_handle;

`ifndef SYNTHESIS
    a_grant_has_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.grant |-> !head_cur.is_null)
        else $error("grant from an empty list");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");

    a_chain_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.chain_wr |-> r_chunks[r_cls] < CHUNK_CNT_W'(CHUNK_LIMIT))
        else $error("chunk chained past the limit");

    a_chain_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.chain_done |=> !head_cur.is_null)
        else $error("list still empty after chaining");
`endif

endmodule

[design/size_class_free_list_allocator_unit.sv]
// Size-class free-list allocator. One request in, one result out.
// Request channel: i_in_valid / o_in_stall with i_mode (0 allocate, 1 free),
// i_size_bytes, i_handle_present and i_block_handle. Result channel:
// o_out_valid / i_out_stall with o_status, o_size_class, o_granted_handle.
// The largest pooled size is written through i_cfg_we / i_cfg_wdata.
// One request is worked at a time. Ignored, oversize, free and exhausted
// requests are decided and their result fired straight away; an allocate from
// a non-empty list first does a registered read of the link store.
// An allocate on an empty list with chunks left first chains a new chunk,
// one link-store write per block, then returns to the decision step.
// The result is loaded as the request finishes and sits in an
// output register; a stalled result holds, and the block then waits for it
// to be taken before finishing the next request.
// Reset empties every class list, clears the chunk counts and sets the
// largest pooled size to 1024; the link store needs no clearing pass, so
// requests are taken as soon as reset is released.
module size_class_free_list_allocator_unit
    import scfla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic                i_handle_present,
    input  logic [BLK_W-1:0]    i_block_handle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [CLASS_W-1:0]  o_size_class,
    output logic [BLK_W-1:0]    o_granted_handle
);

    t_cmd cmd;
    t_sts sts;

    scfla_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    scfla_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_size_bytes    (i_size_bytes),
        .i_handle_present(i_handle_present),
        .i_block_handle  (i_block_handle),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_size_class    (o_size_class),
        .o_granted_handle(o_granted_handle)
    );

endmodule
